// File: rtl/core/abr_pkg.sv
// Shared opcodes, widths and the execute request and result types of the ALU and branch resolver.
`default_nettype none

package abr_pkg;

    localparam int unsigned OP_W   = 8;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned SH_W   = 5;
    localparam int unsigned FLAG_W = 4;

    localparam logic [OP_W-1:0] OP_ADD   = 8'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 8'd1;
    localparam logic [OP_W-1:0] OP_AND   = 8'd2;
    localparam logic [OP_W-1:0] OP_OR    = 8'd3;
    localparam logic [OP_W-1:0] OP_XOR   = 8'd4;
    localparam logic [OP_W-1:0] OP_MUL   = 8'd5;
    localparam logic [OP_W-1:0] OP_SLL   = 8'd6;
    localparam logic [OP_W-1:0] OP_SRA   = 8'd7;
    localparam logic [OP_W-1:0] OP_SRL   = 8'd8;
    localparam logic [OP_W-1:0] OP_BEQ   = 8'd9;
    localparam logic [OP_W-1:0] OP_BNE   = 8'd10;
    localparam logic [OP_W-1:0] OP_BLT   = 8'd11;
    localparam logic [OP_W-1:0] OP_BGT   = 8'd12;
    localparam logic [OP_W-1:0] OP_BLE   = 8'd13;
    localparam logic [OP_W-1:0] OP_BGE   = 8'd14;
    localparam logic [OP_W-1:0] OP_JAL   = 8'd15;
    localparam logic [OP_W-1:0] OP_LOAD  = 8'd16;
    localparam logic [OP_W-1:0] OP_STORE = 8'd17;
    localparam logic [OP_W-1:0] OP_HALT  = 8'd20;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } t_exec_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] alu_out;
        logic                     is_memory;
        logic                     branch_taken;
        logic                     halt_seen;
        logic                     unknown_op;
    } t_exec_res;

endpackage

`default_nettype wire

// File: rtl/core/alu_and_branch_resolve_core.sv
// Top level of the ALU and branch resolver: input register, execute logic, result register.
//
// Usage:
//   A request enters on the s_axis channel: tuser holds the opcode, tdata the two
//   signed operands. One result leaves on the m_axis channel per request: tdata
//   holds alu_out, tuser the four flags.
//   A request accepted into the input register passes the execute logic and waits in
//   the result register, which drives m_axis.
//   Throughput: one request per cycle while m_axis_tready stays high, set by the
//   single-pass execute logic between the two registers; the 32x32 multiplier
//   low word is the longest path.
//   Reset (i_rst_n low at a rising edge) drops both stage valids; no request in
//   flight survives it; the data registers themselves are not reset.
//   When the receiver stalls, the result register holds its request and the input
//   register fills behind it; s_axis_tready then falls until m_axis_tready rises.
//   Bubbles on either side never lose, repeat or reorder results.
`default_nettype none

module alu_and_branch_resolve_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // operand_a [31:0], operand_b [63:32]
    input  wire  [7:0]  s_axis_tuser,   // opcode [7:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // alu_out [31:0]
    output logic [3:0]  m_axis_tuser    // is_memory, branch_taken, halt_seen, unknown_op
);

    logic                 r_s1_valid;
    abr_pkg::t_exec_req   r_s1_req;
    logic                 r_s2_valid;
    abr_pkg::t_exec_res   r_s2_res;
    abr_pkg::t_exec_res   n_s2_res;
    logic                 s1_ready;
    logic                 s2_ready;
    logic                 in_fire;
    logic                 s1_fire;

    assign s2_ready = !r_s2_valid || m_axis_tready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign in_fire  = s_axis_tvalid && s1_ready;
    assign s1_fire  = r_s1_valid && s2_ready;

    assign s_axis_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req.opcode    <= s_axis_tuser;
            r_s1_req.operand_a <= s_axis_tdata[31:0];
            r_s1_req.operand_b <= s_axis_tdata[63:32];
        end
    end

    abr_exec u_exec (
        .i_req (r_s1_req),
        .o_res (n_s2_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_s2_res <= n_s2_res;
        end
    end

    assign m_axis_tvalid = r_s2_valid;
    assign m_axis_tdata  = r_s2_res.alu_out;
    assign m_axis_tuser  = {r_s2_res.unknown_op, r_s2_res.halt_seen,
                            r_s2_res.branch_taken, r_s2_res.is_memory};

    // at most one kind of flag per result
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tuser))
        else $error("more than one result flag set");

    // no data word for taken branches, halt or unknown opcodes
    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2] || m_axis_tuser[3]))
        |-> (m_axis_tdata == '0))
        else $error("nonzero alu_out on a control result");

    // an accepted request occupies the input register next cycle
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted request lost in input register");

    // a request leaving the input register reaches the result register
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_s2_valid)
        else $error("request lost between stages");

    // a stalled result stays valid
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !m_axis_tready) |=> (r_s2_valid && $stable(r_s2_res)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// File: rtl/core/abr_exec.sv
// Combinational execute logic: ALU, shifter, multiplier low word and branch compare.
`default_nettype none

module abr_exec (
    input  wire abr_pkg::t_exec_req i_req,
    output abr_pkg::t_exec_res      o_res
);

    logic [abr_pkg::WORD_W-1:0] a_u;
    logic [abr_pkg::WORD_W-1:0] b_u;
    logic [abr_pkg::WORD_W-1:0] sum;
    logic [abr_pkg::WORD_W-1:0] prod;
    logic [abr_pkg::SH_W-1:0]   shamt;
    logic                       eq;
    logic                       lt;

    assign a_u   = i_req.operand_a;
    assign b_u   = i_req.operand_b;
    assign sum   = a_u + b_u;
    // keep only the low word of the product
    assign prod  = a_u * b_u;
    assign shamt = b_u[abr_pkg::SH_W-1:0];
    assign eq    = (a_u == b_u);
    assign lt    = (i_req.operand_a < i_req.operand_b);

    always_comb begin
        o_res = '0;
        case (i_req.opcode)
            abr_pkg::OP_ADD:   o_res.alu_out = sum;
            abr_pkg::OP_SUB:   o_res.alu_out = a_u - b_u;
            abr_pkg::OP_AND:   o_res.alu_out = a_u & b_u;
            abr_pkg::OP_OR:    o_res.alu_out = a_u | b_u;
            abr_pkg::OP_XOR:   o_res.alu_out = a_u ^ b_u;
            abr_pkg::OP_MUL:   o_res.alu_out = prod;
            abr_pkg::OP_SLL:   o_res.alu_out = a_u << shamt;
            abr_pkg::OP_SRA:   o_res.alu_out = i_req.operand_a >>> shamt;
            abr_pkg::OP_SRL:   o_res.alu_out = a_u >> shamt;
            abr_pkg::OP_BEQ:   o_res.branch_taken = eq;
            abr_pkg::OP_BNE:   o_res.branch_taken = !eq;
            abr_pkg::OP_BLT:   o_res.branch_taken = lt;
            abr_pkg::OP_BGT:   o_res.branch_taken = !lt && !eq;
            abr_pkg::OP_BLE:   o_res.branch_taken = lt || eq;
            abr_pkg::OP_BGE:   o_res.branch_taken = !lt;
            abr_pkg::OP_JAL:   o_res.branch_taken = 1'b1;
            abr_pkg::OP_LOAD,
            abr_pkg::OP_STORE: begin
                o_res.alu_out   = sum;
                o_res.is_memory = 1'b1;
            end
            abr_pkg::OP_HALT:  o_res.halt_seen = 1'b1;
            default:           o_res.unknown_op = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the ALU and branch resolver core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RAND_REQS   = 1950;
    localparam int unsigned DRAIN_AT    = 500;
    localparam int unsigned STEADY_LO   = 1000;
    localparam int unsigned STEADY_HI   = 1300;
    localparam int unsigned IDLE_PCT    = 27;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned N_DIR       = 25;

    typedef struct packed {
        logic [abr_pkg::OP_W-1:0]   op;
        logic [abr_pkg::WORD_W-1:0] a;
        logic [abr_pkg::WORD_W-1:0] b;
        logic                       typed;
        abr_pkg::t_exec_res         want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;     // operand_a [31:0], operand_b [63:32]
    logic [7:0]  s_axis_tuser = '0;     // opcode [7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // alu_out [31:0]
    logic [3:0]  m_axis_tuser;          // is_memory, branch_taken, halt_seen, unknown_op

    // typed expectation rides along with the request it belongs to
    logic                typed_row = 1'b0;
    abr_pkg::t_exec_res  typed_res = '0;

    abr_pkg::t_exec_res  exec_q[$];
    bit          steady = 1'b0;
    int unsigned err_cnt = 0;
    int unsigned n_req = 0, n_res = 0, n_taken = 0, n_mem = 0, n_halt = 0, n_unk = 0;
    int unsigned stall_cycles = 0;

    // expected (op, a, b, typed?, typed result)
    t_dir_row dir_tab [N_DIR] = '{
        '{abr_pkg::OP_ADD,   32'h7fff_ffff, 32'h0000_0001, 1'b1,
            abr_pkg::t_exec_res'{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_SUB,   32'h8000_0000, 32'h0000_0001, 1'b1,
            abr_pkg::t_exec_res'{32'h7fff_ffff, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_AND,   32'hffff_ffff, 32'ha5a5_a5a5, 1'b0,
            abr_pkg::t_exec_res'('0)},
        '{abr_pkg::OP_OR,    32'h0000_0000, 32'h0000_0000, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_XOR,   32'hffff_ffff, 32'hffff_ffff, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_MUL,   32'h7fff_ffff, 32'h7fff_ffff, 1'b0,
            abr_pkg::t_exec_res'('0)},
        '{abr_pkg::OP_MUL,   32'h8000_0000, 32'hffff_ffff, 1'b0,
            abr_pkg::t_exec_res'('0)},
        '{abr_pkg::OP_SLL,   32'h0000_0001, 32'h0000_003f, 1'b1,
            abr_pkg::t_exec_res'{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_SLL,   32'hffff_ffff, 32'h0000_0020, 1'b1,
            abr_pkg::t_exec_res'{32'hffff_ffff, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_SRA,   32'h8000_0000, 32'h0000_001f, 1'b1,
            abr_pkg::t_exec_res'{32'hffff_ffff, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_SRA,   32'h7fff_ffff, 32'hffff_ffff, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_SRL,   32'h8000_0000, 32'h0000_003f, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_BEQ,   32'h8000_0000, 32'h8000_0000, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{abr_pkg::OP_BNE,   32'h0000_0000, 32'h0000_0000, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_BLT,   32'h8000_0000, 32'h7fff_ffff, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{abr_pkg::OP_BGT,   32'hffff_ffff, 32'h0000_0000, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_BLE,   32'h0000_0005, 32'h0000_0005, 1'b0,
            abr_pkg::t_exec_res'('0)},
        '{abr_pkg::OP_BGE,   32'h8000_0000, 32'h7fff_ffff, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_JAL,   32'hffff_ffff, 32'h0000_0000, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{abr_pkg::OP_LOAD,  32'h7fff_ffff, 32'h0000_0001, 1'b1,
            abr_pkg::t_exec_res'{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_STORE, 32'hffff_fffc, 32'h0000_0004, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{abr_pkg::OP_HALT,  32'h1234_5678, 32'h9abc_def0, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{abr_pkg::OP_STORE + 8'd1, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{abr_pkg::OP_HALT - 8'd1, 32'h8000_0000, 32'h8000_0000, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'hff,             32'h7fff_ffff, 32'h0000_0001, 1'b1,
            abr_pkg::t_exec_res'{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1}}
    };

    alu_and_branch_resolve_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic abr_pkg::t_exec_res exec_predict(
        logic [abr_pkg::OP_W-1:0] op,
        logic signed [abr_pkg::WORD_W-1:0] a,
        logic signed [abr_pkg::WORD_W-1:0] b);
        abr_pkg::t_exec_res       r;
        logic [abr_pkg::SH_W-1:0] sh;
        r  = '0;
        sh = b[abr_pkg::SH_W-1:0];
        case (op)
            abr_pkg::OP_ADD:   r.alu_out = a + b;
            abr_pkg::OP_SUB:   r.alu_out = a - b;
            abr_pkg::OP_AND:   r.alu_out = a & b;
            abr_pkg::OP_OR:    r.alu_out = a | b;
            abr_pkg::OP_XOR:   r.alu_out = a ^ b;
            abr_pkg::OP_MUL:   r.alu_out = a * b;
            abr_pkg::OP_SLL:   r.alu_out = a << sh;
            abr_pkg::OP_SRA:   r.alu_out = a >>> sh;
            abr_pkg::OP_SRL:   r.alu_out = $unsigned(a) >> sh;
            abr_pkg::OP_BEQ:   r.branch_taken = (a == b);
            abr_pkg::OP_BNE:   r.branch_taken = (a != b);
            abr_pkg::OP_BLT:   r.branch_taken = (a < b);
            abr_pkg::OP_BGT:   r.branch_taken = (a > b);
            abr_pkg::OP_BLE:   r.branch_taken = (a <= b);
            abr_pkg::OP_BGE:   r.branch_taken = (a >= b);
            abr_pkg::OP_JAL:   r.branch_taken = 1'b1;
            abr_pkg::OP_LOAD, abr_pkg::OP_STORE: begin
                r.alu_out   = a + b;
                r.is_memory = 1'b1;
            end
            abr_pkg::OP_HALT:  r.halt_seen = 1'b1;
            default:           r.unknown_op = 1'b1;
        endcase
        return r;
    endfunction

    // operand mix: extremes, small values near zero, and full random words
    function automatic logic [abr_pkg::WORD_W-1:0] pick_operand();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4, 5:    return $urandom_range(64) - 32;
            default: return $urandom;
        endcase
    endfunction

    task automatic flag_mismatch(string fld, logic [abr_pkg::WORD_W-1:0] want,
                                 logic [abr_pkg::WORD_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
        err_cnt++;
    endtask

    task automatic issue_request(logic [abr_pkg::OP_W-1:0] op,
                                 logic [abr_pkg::WORD_W-1:0] a,
                                 logic [abr_pkg::WORD_W-1:0] b, logic typed,
                                 abr_pkg::t_exec_res want);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {b, a};
        typed_row     <= typed;
        typed_res     <= want;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    // result side: random backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // record accepted requests, check results, watch for a hang
    always @(posedge i_clk) begin
        abr_pkg::t_exec_res want;
        abr_pkg::t_exec_res got;
        bit                 moved;
        moved = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            want = typed_row ? typed_res
                             : exec_predict(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
            exec_q.push_back(want);
            n_req++;
            n_taken += want.branch_taken;
            n_mem   += want.is_memory;
            n_halt  += want.halt_seen;
            n_unk   += want.unknown_op;
            moved = 1'b1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            moved = 1'b1;
            got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2], m_axis_tuser[3]};
            if (exec_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h flags %b",
                         $time, m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end else begin
                want = exec_q.pop_front();
                n_res++;
                if (got.alu_out !== want.alu_out)
                    flag_mismatch("alu_out", want.alu_out, got.alu_out);
                if (got.is_memory !== want.is_memory)
                    flag_mismatch("is_memory", abr_pkg::WORD_W'(want.is_memory),
                                  abr_pkg::WORD_W'(got.is_memory));
                if (got.branch_taken !== want.branch_taken)
                    flag_mismatch("branch_taken", abr_pkg::WORD_W'(want.branch_taken),
                                  abr_pkg::WORD_W'(got.branch_taken));
                if (got.halt_seen !== want.halt_seen)
                    flag_mismatch("halt_seen", abr_pkg::WORD_W'(want.halt_seen),
                                  abr_pkg::WORD_W'(got.halt_seen));
                if (got.unknown_op !== want.unknown_op)
                    flag_mismatch("unknown_op", abr_pkg::WORD_W'(want.unknown_op),
                                  abr_pkg::WORD_W'(got.unknown_op));
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, exec_q.size());
            $display("** alu_and_branch_resolve_core: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [abr_pkg::OP_W-1:0]   op;
        logic [abr_pkg::WORD_W-1:0] a;
        logic [abr_pkg::WORD_W-1:0] b;
        int unsigned                k;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            issue_request(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed,
                          dir_tab[i].want);

        for (int unsigned n = 0; n < RAND_REQS; n++) begin
            // hold off until the pipe is empty once
            if (n == DRAIN_AT) begin
                s_axis_tvalid <= 1'b0;
                while (exec_q.size() != 0) @(posedge i_clk);
            end
            steady = (n >= STEADY_LO && n < STEADY_HI);

            k = $urandom_range(99);
            if (k < 4) begin
                op = abr_pkg::OP_HALT;
            end else if (k < 16) begin
                op = abr_pkg::OP_W'($urandom_range(255));
                while (op <= abr_pkg::OP_STORE || op == abr_pkg::OP_HALT)
                    op = abr_pkg::OP_W'($urandom_range(255));
            end else begin
                op = abr_pkg::OP_W'($urandom_range(abr_pkg::OP_STORE, abr_pkg::OP_ADD));
            end
            a = pick_operand();
            b = pick_operand();
            // give the compares a fair share of equal operands
            if (op >= abr_pkg::OP_BEQ && op <= abr_pkg::OP_BGE && $urandom_range(3) == 0)
                b = a;
            issue_request(op, a, b, 1'b0, '0);
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (exec_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results of %0d requests: %0d branches taken, %0d memory ops,",
                 n_res, n_req, n_taken, n_mem);
        $display("%0d halts and %0d undefined opcodes, under random stalls on both sides.",
                 n_halt, n_unk);
        if (err_cnt == 0) begin
            $display("** alu_and_branch_resolve_core: PASSED **");
        end else begin
            $display("** alu_and_branch_resolve_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
